FILE: hw/rtl/qbal_pkg.sv
// Package: shared types and constants for the quadratic Bezier arc length block.
package qbal_pkg;

    localparam int COORD_W = 32;
    localparam int SUM_W   = 48;
    localparam int STEP_W  = 16;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;
    localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] ctrl_x;
        logic signed [COORD_W-1:0] ctrl_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic                      last_segment;
    } seg_in_t;

    typedef struct packed {
        logic [SUM_W-1:0] total_length;
        logic             path_done;
        logic             saturated;
    } seg_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LA,
        ST_LA_W,
        ST_LC,
        ST_LC_W,
        ST_DIFF,
        ST_SQX,
        ST_SQY,
        ST_SQRT,
        ST_ACC,
        ST_OUT
    } eng_state_t;

endpackage

FILE: hw/rtl/qbal_front.sv
// Front end: request intake with a two-entry queue toward the engine.
module qbal_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  qbal_pkg::seg_in_t s_data,
    output logic              q_valid,
    input  logic              q_ready,
    output qbal_pkg::seg_in_t q_data
);
    qbal_pkg::seg_in_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = mem_reg[rp_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= s_data;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: hw/rtl/qbal_sqrt.sv
// Bit-serial integer square root of a 65-bit value, one result bit per cycle.
module qbal_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [64:0] radicand,
    output logic        done,
    output logic [32:0] root
);
    logic [66:0] rem_reg;
    logic [66:0] rad_reg;
    logic [32:0] root_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [66:0] rem_sh, trial;

    assign rem_sh = {rem_reg[64:0], rad_reg[66:65]};
    assign trial  = {32'd0, root_reg, 2'b01};
    assign root   = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rem_reg  <= '0;
                rad_reg  <= {1'b0, radicand, 1'b0};
                root_reg <= '0;
                cnt_reg  <= 6'd33;
            end else if (busy_reg) begin
                rad_reg <= {rad_reg[64:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[31:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[31:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: hw/rtl/qbal_engine.sv
// Back end: sample loop with shared interpolator, distance and saturating sum.
module qbal_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               q_valid,
    output logic               q_ready,
    input  qbal_pkg::seg_in_t  q_data,
    output logic               m_valid,
    input  logic               m_ready,
    output qbal_pkg::seg_out_t m_data
);
    localparam logic [16:0] T_ONE = 17'h10000;

    qbal_pkg::eng_state_t state_reg, state_next;
    qbal_pkg::seg_in_t    seg_reg;
    logic [15:0] step_reg;
    logic [16:0] t_reg;
    logic [47:0] sum_reg;
    logic signed [32:0] ax_reg, ay_reg, px_reg, py_reg;
    logic [32:0] dx_reg, dy_reg;
    logic [64:0] sq_reg;
    logic        sel_reg;
    logic        out_valid_reg;

    // shared lerp: two multiplies of 33x17, registered result
    logic signed [32:0] la, lb, lr0, lr1;
    logic signed [17:0] tw, tc;
    logic signed [51:0] lacc;
    logic signed [32:0] lres_reg;
    logic [32:0]        sq_op;
    logic [65:0]        sqp;
    logic               sq_start, sq_done;
    logic [32:0]        sq_root;
    logic [48:0]        sum_add;
    logic [16:0]        step_eff, t_new;
    logic               load_out;

    assign tw  = {1'b0, t_reg};
    assign tc  = $signed({1'b0, T_ONE - t_reg});
    assign lacc = la * tc + lb * tw + 52'sd32768;

    always_comb begin
        la = '0;
        lb = '0;
        unique case (state_reg)
            qbal_pkg::ST_LA: begin
                unique case (sel_reg)
                    1'b0: begin
                        la = 33'(seg_reg.start_x); lb = 33'(seg_reg.ctrl_x);
                    end
                    1'b1: begin
                        la = 33'(seg_reg.start_y); lb = 33'(seg_reg.ctrl_y);
                    end
                endcase
            end
            qbal_pkg::ST_LA_W: begin
                unique case (sel_reg)
                    1'b0: begin
                        la = 33'(seg_reg.ctrl_x); lb = 33'(seg_reg.end_x);
                    end
                    1'b1: begin
                        la = 33'(seg_reg.ctrl_y); lb = 33'(seg_reg.end_y);
                    end
                endcase
            end
            qbal_pkg::ST_LC: begin
                la = sel_reg ? ay_reg : ax_reg;
                lb = lr1;
            end
            default: begin
                la = '0;
                lb = '0;
            end
        endcase
    end
    assign lr0 = lacc[48:16];
    assign lr1 = lres_reg;

    assign sq_op    = (state_reg == qbal_pkg::ST_SQX) ? dx_reg : dy_reg;
    assign sqp      = {33'd0, sq_op} * {33'd0, sq_op};
    assign sq_start = (state_reg == qbal_pkg::ST_SQY);
    assign sum_add  = {1'b0, sum_reg} + {16'd0, sq_root};
    assign step_eff = (step_reg == 16'd0) ? 17'd1 : {1'b0, step_reg};
    assign t_new    = t_reg + step_eff;
    assign load_out = (state_reg == qbal_pkg::ST_OUT) && (!out_valid_reg || m_ready);

    qbal_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sq_reg + {1'b0, sqp[63:0]}),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            qbal_pkg::ST_IDLE: if (q_valid) state_next = qbal_pkg::ST_LA;
            qbal_pkg::ST_LA:   state_next = qbal_pkg::ST_LA_W;
            qbal_pkg::ST_LA_W: state_next = qbal_pkg::ST_LC;
            qbal_pkg::ST_LC:   state_next = qbal_pkg::ST_LC_W;
            qbal_pkg::ST_LC_W: state_next = sel_reg ? qbal_pkg::ST_DIFF : qbal_pkg::ST_LA;
            qbal_pkg::ST_DIFF: state_next = qbal_pkg::ST_SQX;
            qbal_pkg::ST_SQX:  state_next = qbal_pkg::ST_SQY;
            qbal_pkg::ST_SQY:  state_next = qbal_pkg::ST_SQRT;
            qbal_pkg::ST_SQRT: if (sq_done) state_next = qbal_pkg::ST_ACC;
            qbal_pkg::ST_ACC:  state_next = (t_new >= T_ONE) ? qbal_pkg::ST_OUT
                                                             : qbal_pkg::ST_LA;
            qbal_pkg::ST_OUT:  if (!out_valid_reg || m_ready) state_next = qbal_pkg::ST_IDLE;
            default:           state_next = qbal_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        q_ready = (state_reg == qbal_pkg::ST_IDLE);
    end

    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        lres_reg <= lr0;
        unique case (state_reg)
            qbal_pkg::ST_IDLE: begin
                seg_reg <= q_data;
                px_reg  <= 33'(q_data.start_x);
                py_reg  <= 33'(q_data.start_y);
            end
            qbal_pkg::ST_LA_W: begin
                if (sel_reg) ay_reg <= lr1; else ax_reg <= lr1;
            end
            qbal_pkg::ST_LC_W: begin
                if (sel_reg) dy_reg <= (lr1 >= py_reg) ? 33'(lr1 - py_reg) : 33'(py_reg - lr1);
                else         dx_reg <= (lr1 >= px_reg) ? 33'(lr1 - px_reg) : 33'(px_reg - lr1);
                if (sel_reg) py_reg <= lr1; else px_reg <= lr1;
            end
            qbal_pkg::ST_SQX: sq_reg <= 65'(sqp);
            default: ;
        endcase
        if (!aresetn) begin
            state_reg     <= qbal_pkg::ST_IDLE;
            step_reg      <= qbal_pkg::STEP_RESET;
            sum_reg       <= '0;
            t_reg         <= '0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) step_reg <= cfg_wdata;
            if (load_out) out_valid_reg <= 1'b1;
            else if (m_valid && m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                qbal_pkg::ST_IDLE: begin
                    t_reg   <= '0;
                    sel_reg <= 1'b0;
                end
                qbal_pkg::ST_LC_W: sel_reg <= ~sel_reg;
                qbal_pkg::ST_ACC: begin
                    sum_reg <= sum_add[48] ? qbal_pkg::SUM_MAX : sum_add[47:0];
                    t_reg   <= t_new;
                end
                qbal_pkg::ST_OUT: begin
                    if (load_out) begin
                        m_data.total_length <= sum_reg;
                        m_data.path_done    <= seg_reg.last_segment;
                        m_data.saturated    <= (sum_reg == qbal_pkg::SUM_MAX);
                        if (seg_reg.last_segment) sum_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: hw/rtl/quadratic_bezier_arc_length.sv
// Top level: quadratic Bezier arc length estimator.
// Each segment is processed as ceil(65536/step_size) samples; each sample runs the lerp
// passes, the squares and the square root in turn.
// Throughput: one segment at a time in the engine; the front queue holds two more.
// Reset (aresetn, synchronous, active low): sum cleared, step_size set to 655.
module quadratic_bezier_arc_length (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  qbal_pkg::seg_in_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output qbal_pkg::seg_out_t m_data
);
    logic              q_valid, q_ready;
    qbal_pkg::seg_in_t q_data;

    qbal_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    qbal_engine u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

FILE: dv/tb_top.sv
// Testbench for quadratic_bezier_arc_length: predicted path lengths checked per request.
module tb_top;

    localparam int WATCHDOG_LIMIT = 12_000_000;
    localparam int T_ONE          = 65536;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     cfg_we;
    logic [15:0] cfg_wdata;
    logic     s_valid;
    logic     s_ready;
    qbal_pkg::seg_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    qbal_pkg::seg_out_t m_data;

    qbal_pkg::seg_out_t         length_q[$];
    logic [qbal_pkg::SUM_W-1:0] path_len;
    logic [15:0]      step_reg;
    int  tx_gap_max, rx_gap_max;
    bit  hold_req;
    int  fail_cnt = 0, seg_cnt = 0, res_cnt = 0, sat_cnt = 0, done_cnt = 0, idle_cnt = 0;

    always #5 aclk = ~aclk;

    quadratic_bezier_arc_length DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    function automatic longint lerp_q16(longint a, longint b, longint t);
        longint acc;
        acc = a * (T_ONE - t) + b * t + 32768;
        return acc >>> 16;
    endfunction

    function automatic logic [63:0] dist_floor(longint x0, longint y0, longint x1, longint y1);
        logic [67:0] ax, ay, norm, cand, root;
        ax = (x0 >= x1) ? 68'(x0 - x1) : 68'(x1 - x0);
        ay = (y0 >= y1) ? 68'(y0 - y1) : 68'(y1 - y0);
        norm = ax * ax + ay * ay;
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = root | (68'd1 << b);
            if (cand * cand <= norm) root = cand;
        end
        return root[63:0];
    endfunction

    function automatic qbal_pkg::seg_out_t predict_length(qbal_pkg::seg_in_t s);
        qbal_pkg::seg_out_t r;
        longint     ax, ay, bx, by, cx, cy, px, py, step;
        logic [63:0] sum;
        step = (step_reg == 0) ? 1 : step_reg;
        px   = s.start_x;
        py   = s.start_y;
        sum  = path_len;
        for (longint t = 0; t < T_ONE; t += step) begin
            ax = lerp_q16(s.start_x, s.ctrl_x, t);
            ay = lerp_q16(s.start_y, s.ctrl_y, t);
            bx = lerp_q16(s.ctrl_x, s.end_x, t);
            by = lerp_q16(s.ctrl_y, s.end_y, t);
            cx = lerp_q16(ax, bx, t);
            cy = lerp_q16(ay, by, t);
            sum += dist_floor(px, py, cx, cy);
            if (sum > qbal_pkg::SUM_MAX) sum = qbal_pkg::SUM_MAX;
            px = cx;
            py = cy;
        end
        r.total_length = sum[qbal_pkg::SUM_W-1:0];
        r.path_done    = s.last_segment;
        r.saturated    = (sum[qbal_pkg::SUM_W-1:0] == qbal_pkg::SUM_MAX);
        path_len       = s.last_segment ? '0 : sum[qbal_pkg::SUM_W-1:0];
        return r;
    endfunction

    task automatic send_seg(qbal_pkg::seg_in_t s);
        int gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        length_q.push_back(predict_length(s));
        seg_cnt++;
        s_valid <= 1'b1;
        s_data  <= s;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        wait (length_q.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_step(logic [15:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        step_reg  = v;
    endtask

    function automatic qbal_pkg::seg_in_t mk_seg(int sx, int sy, int cx, int cy, int ex, int ey,
                                                 bit last);
        qbal_pkg::seg_in_t s;
        s.start_x = sx; s.start_y = sy;
        s.ctrl_x  = cx; s.ctrl_y  = cy;
        s.end_x   = ex; s.end_y   = ey;
        s.last_segment = last;
        return s;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(3, 0))
            0:       return $urandom;
            1:       return $urandom_range(1, 0) ? 32'sh7fffffff : 32'sh80000000;
            default: return int'($urandom_range(2_000_000, 0)) - 1_000_000;
        endcase
    endfunction

    function automatic qbal_pkg::seg_in_t rand_seg();
        return mk_seg(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), $urandom_range(1, 0));
    endfunction

    // receiver: random stalls, with an optional long hold
    initial begin
        int gap;
        m_ready = 1'b1;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                res_cnt++;
                if (length_q.size() == 0) begin
                    $error("unexpected result: total_length %0h", m_data.total_length);
                    fail_cnt++;
                end else begin
                    qbal_pkg::seg_out_t e;
                    e = length_q.pop_front();
                    if (m_data.total_length !== e.total_length) begin
                        $error("total_length exp %0h got %0h", e.total_length,
                               m_data.total_length);
                        fail_cnt++;
                    end
                    if (m_data.path_done !== e.path_done) begin
                        $error("path_done exp %0b got %0b", e.path_done, m_data.path_done);
                        fail_cnt++;
                    end
                    if (m_data.saturated !== e.saturated) begin
                        $error("saturated exp %0b got %0b", e.saturated, m_data.saturated);
                        fail_cnt++;
                    end
                    if (e.saturated) sat_cnt++;
                    if (e.path_done) done_cnt++;
                end
                gap = hold_req ? 400 : $urandom_range(rx_gap_max, 0);
                hold_req = 1'b0;
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic test_default_step();
        send_seg(mk_seg(0, 0, 0, 0, 0, 0, 0));
        send_seg(mk_seg(0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 0, 0));
        send_seg(mk_seg(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                        32'sh80000000, 32'sh80000000, 1));
    endtask

    task automatic test_directed();
        write_step(16'd16384);
        send_seg(mk_seg(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                        32'sh80000000, 32'sh80000000, 0));
        send_seg(mk_seg(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                        32'sh7fffffff, 32'sh7fffffff, 1));
        send_seg(mk_seg(32'sh80000000, 32'sh80000000, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 0));
        send_seg(mk_seg(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                        32'sh7fffffff, 32'sh80000000, 0));
        send_seg(mk_seg(-1, -1, 32'sh40000000, -5, 3, 32'shc0000000, 1));
        send_seg(mk_seg(-32'h10000, 32'h30000, 5, -7, -32'h20000, 32'h7000, 1));
        send_seg(mk_seg(-1, 1, -1, 1, 1, -1, 0));
        send_seg(mk_seg(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
                        32'h5555_5555, 32'haaaa_aaaa, 1));
    endtask

    task automatic test_step_extremes();
        write_step(16'd65535);
        send_seg(mk_seg(32'sh80000000, 32'sh80000000, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 0));
        send_seg(mk_seg(0, 0, 32'sh7fffffff, 0, 32'sh7fffffff, 32'sh7fffffff, 1));
        write_step(16'd1);
        send_seg(mk_seg(0, 0, 32'h100, 32'h100, 32'h200, 0, 1));
        write_step(16'd0);  // zero step behaves as one
        send_seg(mk_seg(0, 0, 32'h0001_0000, 32'h0003_0000, 32'h0002_0000, 0, 1));
    endtask

    task automatic test_random();
        logic [15:0] steps[6] = '{16'd65535, 16'd40000, 16'd32768, 16'd21846,
                                  16'd13107, 16'd9000};
        int sent, len, x, y;
        qbal_pkg::seg_in_t s;
        sent = 0;
        while (sent < 300) begin
            if (sent % 50 == 0) begin
                write_step((sent == 150) ? 16'd6553 : steps[$urandom_range(5, 0)]);
                tx_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 13;
                rx_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 13;
            end
            if ($urandom_range(4, 0) == 0) begin
                send_seg(rand_seg());
                sent++;
            end else begin
                len = $urandom_range(8, 1);
                x = rand_coord();
                y = rand_coord();
                for (int i = 0; i < len; i++) begin
                    s = mk_seg(x, y, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                               i == len - 1);
                    send_seg(s);
                    x = s.end_x;
                    y = s.end_y;
                    sent++;
                end
            end
        end
    endtask

    task automatic test_backpressure();
        write_step(16'd32768);
        tx_gap_max = 0;
        rx_gap_max = 3;
        hold_req = 1'b1;
        repeat (8) send_seg(rand_seg());
        drain();
        repeat (3) send_seg(rand_seg());
        drain();
        repeat (3) send_seg(rand_seg());
    endtask

    task automatic test_long_path();
        write_step(16'd65535);
        tx_gap_max = 0;
        rx_gap_max = 0;
        repeat (12) send_seg(mk_seg(32'sh80000000, 32'sh80000000, 0, 0,
                                    32'sh7fffffff, 32'sh7fffffff, 0));
        send_seg(mk_seg(0, 0, 32'h10000, 0, 32'h20000, 0, 1));
        send_seg(mk_seg(0, 0, 32'h10000, 0, 32'h20000, 0, 1));
    endtask

    initial begin
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_valid    = 1'b0;
        s_data     = '0;
        hold_req   = 1'b0;
        tx_gap_max = 13;
        rx_gap_max = 13;
        path_len = '0;
        step_reg = qbal_pkg::STEP_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_step();
        test_directed();
        test_step_extremes();
        test_random();
        test_backpressure();
        test_long_path();
        drain();

        $display("Sent %0d segments, checked %0d results (%0d path ends, %0d saturated).",
                 seg_cnt, res_cnt, done_cnt, sat_cnt);
        $display("Steps 0..65535, coordinate extremes, chained and long paths, stalls.");
        if (fail_cnt == 0 && length_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
